@@ rtl/assert_macros.svh @@
// Assertion macros shared by the order book RTL.
// Needs only a clock and an active-low reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define OLOB_ASSERT_IMPLY(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("olob assertion failed");

// Condition holds at every clock edge out of reset.
`define OLOB_ASSERT_ALWAYS(label, clk_s, rstn_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("olob assertion failed");

`endif

@@ rtl/olob_pkg.sv @@
// Shared types and constants of the limit order book matcher.
// No dependencies.
`default_nettype none

package olob_pkg;

    // Incoming order, one transfer per order
    typedef struct packed {
        logic        action;
        logic        is_buy;
        logic [19:0] limit_price;
        logic [31:0] quantity;
        logic [63:0] order_id;
        logic [63:0] timestamp;
    } order_t;

    // One result transfer: a trade or the final summary
    typedef struct packed {
        logic        result_kind;
        logic [63:0] maker_id;
        logic [31:0] trade_qty;
        logic [19:0] trade_price;
        logic        maker_removed;
        logic [2:0]  order_status;
        logic [31:0] remaining_qty;
        logic [19:0] best_bid_price;
        logic [31:0] best_bid_size;
        logic [19:0] best_ask_price;
        logic [31:0] best_ask_size;
        logic        is_last;
    } result_t;

    // Summary status codes
    localparam logic [2:0] ST_FILLED   = 3'd0;
    localparam logic [2:0] ST_RESTED   = 3'd1;
    localparam logic [2:0] ST_PARTIAL  = 3'd2;
    localparam logic [2:0] ST_MKT_REM  = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_IGNORED  = 3'd5;

    localparam logic KIND_TRADE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;
    localparam logic ACT_MARKET   = 1'b1;

    // Commands to one side of the book
    typedef struct packed {
        logic drop;
        logic upd_front;
        logic insert;
        logic walk_clr;
        logic walk_step;
    } side_cmd_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic trade;
        logic decide;
        logic walk_clr;
        logic walk_step;
        logic summary;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic can_trade;
        logic walks_done;
    } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/fifo_limit_order_book_matcher.sv @@
// Top level of the price-time priority order matcher.
// Depends on olob_pkg, olob_ctrl, olob_dp (and olob_side below it).
//
// Usage:
//   Drive order and raise start; the order transfers at the clock edge where
//   start is high and busy is low, and busy stays high until the summary.
//   Results come on result with a one-cycle result_valid strobe: one trade
//   per resting order touched, one per cycle, then the summary (is_last).
//   The receiver cannot stall; every strobe is a transfer.
// Sequence per order:
//   load, one trade per resting order touched, rest or reject the
//   remainder, start the level walk, walk both sides, then issue the summary,
//   which shows on result the cycle after. Per side the walk takes one step
//   per entry at the best price, plus one when entries lie behind that
//   level (none when empty); the walk lasts as long as the longer side's, at
//   most SLOTS_PER_SIDE steps. The next order can transfer in the cycle the
//   summary is on result.
// Reset:
//   rst_n clears both book sides to empty and returns the controller to idle.
`default_nettype none

module fifo_limit_order_book_matcher
    import olob_pkg::*;
#(
    parameter int SLOTS_PER_SIDE = 32,
    parameter int PRICE_BITS     = 20
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire order_t order,
    output logic        result_valid,
    output result_t     result
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    olob_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    olob_dp #(.SLOTS(SLOTS_PER_SIDE), .PW(PRICE_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .order        (order),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

@@ rtl/olob_side.sv @@
// One side of the book: sorted entries in shift registers, best at index 0.
// Depends on olob_pkg; uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module olob_side
    import olob_pkg::*;
#(
    parameter int SLOTS = 32,
    parameter int PW    = 20,
    parameter bit DESC  = 1'b1
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire side_cmd_t                  cmd,
    input  wire logic [PW-1:0]              new_price,
    input  wire logic [31:0]                new_qty,
    input  wire logic [63:0]                new_id,
    input  wire logic [31:0]                front_qty_new,
    output logic [PW-1:0]                   front_price,
    output logic [31:0]                     front_qty,
    output logic [63:0]                     front_id,
    output logic                            empty,
    output logic                            full,
    output logic [31:0]                     level_size,
    output logic                            walk_done
);

    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(SLOTS);

    logic [PW-1:0] pr_reg  [SLOTS];
    logic [31:0]   qt_reg  [SLOTS];
    logic [63:0]   id_reg  [SLOTS];
    logic [CW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic [31:0]   sum_reg;
    logic          done_reg;
    logic [SLOTS-1:0] keep;
    logic [32:0]   sum_wide;
    logic          same_level;

    assign front_price = pr_reg[0];
    assign front_qty   = qt_reg[0];
    assign front_id    = id_reg[0];
    assign empty       = (count_reg == '0);
    assign full        = (count_reg == CW'(SLOTS));
    assign level_size  = sum_reg;
    assign walk_done   = done_reg;

    // entries that stay ahead of a new order (equal or better price)
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            keep[i] = (CW'(i) < count_reg) &&
                      (DESC ? (pr_reg[i] >= new_price) : (pr_reg[i] <= new_price));
        end
    end

    // entry storage: shift out front, shift in sorted
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            if (cmd.drop)
            begin
                pr_reg[i] <= pr_reg[(i + 1) % SLOTS];
                qt_reg[i] <= qt_reg[(i + 1) % SLOTS];
                id_reg[i] <= id_reg[(i + 1) % SLOTS];
            end
            else if (cmd.insert && !keep[i])
            begin
                if (i == 0 || keep[(i + SLOTS - 1) % SLOTS])
                begin
                    pr_reg[i] <= new_price;
                    qt_reg[i] <= new_qty;
                    id_reg[i] <= new_id;
                end
                else
                begin
                    pr_reg[i] <= pr_reg[(i + SLOTS - 1) % SLOTS];
                    qt_reg[i] <= qt_reg[(i + SLOTS - 1) % SLOTS];
                    id_reg[i] <= id_reg[(i + SLOTS - 1) % SLOTS];
                end
            end
            else if (cmd.upd_front && i == 0)
            begin
                qt_reg[i] <= front_qty_new;
            end
        end
    end

    // level walk: sum sizes at the best price, one entry a cycle
    assign same_level = (pr_reg[idx_reg] == pr_reg[0]);
    assign sum_wide   = {1'b0, sum_reg} + {1'b0, qt_reg[idx_reg]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            sum_reg   <= '0;
            done_reg  <= 1'b1;
        end
        else
        begin
            if (cmd.drop)
                count_reg <= count_reg - 1'b1;
            else if (cmd.insert)
                count_reg <= count_reg + 1'b1;

            if (cmd.walk_clr)
            begin
                idx_reg  <= '0;
                sum_reg  <= '0;
                done_reg <= (count_reg == '0);
            end
            else if (cmd.walk_step && !done_reg)
            begin
                if (same_level)
                begin
                    sum_reg <= sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                    if (CW'(idx_reg) + 1'b1 == count_reg)
                        done_reg <= 1'b1;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
                else
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    `OLOB_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(SLOTS))
    `OLOB_ASSERT_IMPLY(a_no_drop_empty, clk, rst_n, cmd.drop, count_reg != '0)

endmodule

`default_nettype wire

@@ rtl/olob_dp.sv @@
// Datapath: order registers, match arithmetic, result register, both book sides.
// Depends on olob_pkg and olob_side; uses assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module olob_dp
    import olob_pkg::*;
#(
    parameter int SLOTS = 32,
    parameter int PW    = 20
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire order_t  order,
    input  wire dp_cmd_t cmd,
    output dp_sts_t      sts,
    output logic         result_valid,
    output result_t      result
);

    logic          market_reg;
    logic          buy_reg;
    logic [PW-1:0] price_reg;
    logic [31:0]   qty_reg;
    logic [63:0]   id_reg;
    logic [31:0]   rem_reg;
    logic [2:0]    status_reg;
    logic          valid_reg;
    result_t       res_reg;

    side_cmd_t     bid_cmd, ask_cmd;
    logic [PW-1:0] bid_fp, ask_fp, opp_fp;
    logic [31:0]   bid_fq, ask_fq, opp_fq;
    logic [63:0]   bid_fid, ask_fid, opp_fid;
    logic          bid_empty, ask_empty, bid_full, ask_full;
    logic [31:0]   bid_sum, ask_sum;
    logic          bid_done, ask_done;
    logic          opp_empty, own_full, crossing, removed, insert_ok;
    logic [31:0]   fill, rem_after;
    logic [31:0]   fp_ext, bp_ext, ap_ext;

    // opposite side front and match decision
    assign opp_fp    = buy_reg ? ask_fp : bid_fp;
    assign opp_fq    = buy_reg ? ask_fq : bid_fq;
    assign opp_fid   = buy_reg ? ask_fid : bid_fid;
    assign opp_empty = buy_reg ? ask_empty : bid_empty;
    assign own_full  = buy_reg ? bid_full : ask_full;
    assign crossing  = market_reg || (buy_reg ? (price_reg >= opp_fp) : (price_reg <= opp_fp));
    assign removed   = (opp_fq <= rem_reg);
    assign fill      = removed ? opp_fq : rem_reg;
    assign rem_after = rem_reg - fill;
    assign insert_ok = (rem_reg != '0) && (market_reg != ACT_MARKET) && !own_full;

    assign sts.can_trade  = (rem_reg != '0) && !opp_empty && crossing;
    assign sts.walks_done = bid_done && ask_done;

    // side commands
    always_comb
    begin
        bid_cmd = '0;
        ask_cmd = '0;
        bid_cmd.drop      = cmd.trade && !buy_reg && removed;
        bid_cmd.upd_front = cmd.trade && !buy_reg && !removed;
        bid_cmd.insert    = cmd.decide && buy_reg && insert_ok;
        ask_cmd.drop      = cmd.trade && buy_reg && removed;
        ask_cmd.upd_front = cmd.trade && buy_reg && !removed;
        ask_cmd.insert    = cmd.decide && !buy_reg && insert_ok;
        bid_cmd.walk_clr  = cmd.walk_clr;
        ask_cmd.walk_clr  = cmd.walk_clr;
        bid_cmd.walk_step = cmd.walk_step;
        ask_cmd.walk_step = cmd.walk_step;
    end

    olob_side #(.SLOTS(SLOTS), .PW(PW), .DESC(1'b1)) u_bid (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (bid_cmd),
        .new_price     (price_reg),
        .new_qty       (rem_reg),
        .new_id        (id_reg),
        .front_qty_new (bid_fq - rem_reg),
        .front_price   (bid_fp),
        .front_qty     (bid_fq),
        .front_id      (bid_fid),
        .empty         (bid_empty),
        .full          (bid_full),
        .level_size    (bid_sum),
        .walk_done     (bid_done)
    );

    olob_side #(.SLOTS(SLOTS), .PW(PW), .DESC(1'b0)) u_ask (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (ask_cmd),
        .new_price     (price_reg),
        .new_qty       (rem_reg),
        .new_id        (id_reg),
        .front_qty_new (ask_fq - rem_reg),
        .front_price   (ask_fp),
        .front_qty     (ask_fq),
        .front_id      (ask_fid),
        .empty         (ask_empty),
        .full          (ask_full),
        .level_size    (ask_sum),
        .walk_done     (ask_done)
    );

    // price widths back to the 20-bit result fields
    assign fp_ext = 32'(opp_fp);
    assign bp_ext = bid_empty ? '0 : 32'(bid_fp);
    assign ap_ext = ask_empty ? '0 : 32'(ask_fp);

    // order registers and status
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            market_reg <= order.action;
            buy_reg    <= order.is_buy;
            price_reg  <= PW'({12'b0, order.limit_price});
            qty_reg    <= order.quantity;
            id_reg     <= order.order_id;
            rem_reg    <= order.quantity;
        end
        else if (cmd.trade)
        begin
            rem_reg <= rem_after;
        end

        if (cmd.decide)
        begin
            if (qty_reg == '0)
                status_reg <= ST_IGNORED;
            else if (rem_reg == '0)
                status_reg <= ST_FILLED;
            else if (market_reg == ACT_MARKET)
                status_reg <= ST_MKT_REM;
            else if (own_full)
                status_reg <= ST_REJECTED;
            else if (rem_reg == qty_reg)
                status_reg <= ST_RESTED;
            else
                status_reg <= ST_PARTIAL;
        end
    end

    // result register: payload, every field written once per transfer
    always_ff @(posedge clk)
    begin
        if (cmd.trade)
        begin
            res_reg.result_kind    <= KIND_TRADE;
            res_reg.maker_id       <= opp_fid;
            res_reg.trade_qty      <= fill;
            res_reg.trade_price    <= fp_ext[19:0];
            res_reg.maker_removed  <= removed;
            res_reg.order_status   <= '0;
            res_reg.remaining_qty  <= rem_after;
            res_reg.best_bid_price <= '0;
            res_reg.best_bid_size  <= '0;
            res_reg.best_ask_price <= '0;
            res_reg.best_ask_size  <= '0;
            res_reg.is_last        <= 1'b0;
        end
        else if (cmd.summary)
        begin
            res_reg.result_kind    <= KIND_SUMMARY;
            res_reg.maker_id       <= '0;
            res_reg.trade_qty      <= '0;
            res_reg.trade_price    <= '0;
            res_reg.maker_removed  <= 1'b0;
            res_reg.order_status   <= status_reg;
            res_reg.remaining_qty  <= rem_reg;
            res_reg.best_bid_price <= bp_ext[19:0];
            res_reg.best_bid_size  <= bid_empty ? '0 : bid_sum;
            res_reg.best_ask_price <= ap_ext[19:0];
            res_reg.best_ask_size  <= ask_empty ? '0 : ask_sum;
            res_reg.is_last        <= 1'b1;
        end
    end

    // result register: strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cmd.trade || cmd.summary;
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

    `OLOB_ASSERT_IMPLY(a_trade_legal, clk, rst_n, cmd.trade, sts.can_trade)
    `OLOB_ASSERT_IMPLY(a_trade_nonzero, clk, rst_n,
        valid_reg && !res_reg.is_last, res_reg.trade_qty != '0)
    `OLOB_ASSERT_IMPLY(a_filled_zero_rem, clk, rst_n,
        valid_reg && res_reg.is_last && res_reg.order_status == ST_FILLED,
        res_reg.remaining_qty == '0)

endmodule

`default_nettype wire

@@ rtl/olob_ctrl.sv @@
// Controller: sequences load, trades, rest/decide, level walk and summary.
// Depends on olob_pkg.
`default_nettype none

module olob_ctrl
    import olob_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire dp_sts_t sts,
    output dp_cmd_t      cmd,
    output logic         busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_INIT,
        S_WALK
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg;

    // commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                if (sts.can_trade)
                begin
                    cmd.trade = 1'b1;
                end
                else
                begin
                    cmd.decide = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.walk_clr = 1'b1;
                state_next   = S_WALK;
            end
            S_WALK:
            begin
                if (sts.walks_done)
                begin
                    cmd.summary = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire
